// ===== rtl/core/ndd_pkg.sv =====
// Package for the Newton divided-difference interpolator.
// Types, constants and state codes shared by the top level and the divider.
// No dependencies.
`default_nettype none
package ndd_pkg;
	localparam int unsigned MAX_POINTS_DEF = 16;
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam logic [4:0] POINT_COUNT_RST = 5'd5;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_ZDIV = 2'd2;

	typedef struct packed {
		logic action;
		logic [3:0] node_index;
		logic signed [31:0] node_x;
		logic signed [31:0] node_y;
		logic signed [31:0] query_x;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic [1:0] status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_COPY, S_RD, S_RD2, S_SUB, S_DIV, S_DWR, S_PMUL, S_AMUL,
		S_ACC, S_DONE
	} state_t;

	// saturate a 34-bit sum/difference into 32 bits
	function automatic logic [32:0] sat34(input logic signed [33:0] v);
		logic [32:0] r;
		if (v > 34'sh07FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
		else if (v < -34'sh080000000) r = {1'b1, 32'h80000000};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ndd_div.sv =====
// Sequential restoring divider: (a << FRAC_BITS) / b, truncated toward zero,
// saturated to 32 bits. One quotient bit per cycle. Uses ndd_pkg.
`default_nettype none
module ndd_div import ndd_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic signed [31:0] a,
	input wire logic signed [31:0] b,
	output logic done,
	output logic signed [31:0] q,
	output logic sat
);
	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] num_q, quo_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic neg_q, run_q;
	logic [CW-1:0] cnt_q;
	logic [32:0] trial;
	logic [NW:0] sq;

	assign trial = {rem_q[31:0], num_q[NW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= !go && run_q && (cnt_q == CW'(1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
				num_q <= {(a[31] ? 32'(-a) : 32'(a)), {FRAC_BITS{1'b0}}};
				den_q <= b[31] ? 32'(-b) : 32'(b);
				neg_q <= a[31] ^ b[31];
				rem_q <= '0;
				quo_q <= '0;
			end else if (run_q) begin
				if (!trial[32]) rem_q <= trial;
				else rem_q <= {rem_q[31:0], num_q[NW-1]};
				num_q <= {num_q[NW-2:0], 1'b0};
				quo_q <= {quo_q[NW-2:0], ~trial[32]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) run_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sq = neg_q ? (NW+1)'(-{1'b0, quo_q}) : {1'b0, quo_q};
		sat = 1'b0;
		q = sq[31:0];
		if (!neg_q && quo_q > NW'(32'h7FFFFFFF)) begin
			sat = 1'b1;
			q = 32'h7FFFFFFF;
		end else if (neg_q && quo_q > NW'(33'h80000000)) begin
			sat = 1'b1;
			q = 32'h80000000;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/newton_divided_difference_interp.sv =====
// Newton divided-difference interpolator, top level.
// Node memories, difference table, sequencer and multiplier; uses ndd_pkg
// and ndd_div.
//
// Load items write one node (x, y) in the cycle they are accepted; busy
// stays low, so loads can follow back to back. An evaluate item copies y
// into the difference table, then for each order k runs N-k divisions on
// the shared bit-serial divider, then two multiplies and an add for the
// Newton sum. A zero divisor ends the evaluation early. The result
// appears for one cycle with done high and cannot be stalled: the
// receiver must take it. point_count is written through cfg_valid/ready;
// the user must write it only while idle, the block does not enforce it.
// cfg_ready is always high.
`default_nettype none
module newton_divided_difference_interp import ndd_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire in_item_t in_item,
	output logic done,
	output out_item_t out_item,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [4:0] cfg_data
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	// memories: x nodes, y nodes, difference table (registered read)
	logic signed [31:0] xmem [MAX_POINTS];
	logic signed [31:0] ymem [MAX_POINTS];
	logic signed [31:0] dmem [MAX_POINTS];
	logic [AW-1:0] xra, dra;
	logic signed [31:0] xrd_q, drd_q, yrd_q;
	logic dwe;
	logic [AW-1:0] dwa;
	logic signed [31:0] dwd;

	state_t st_q, st_d;
	logic [4:0] pc_q;
	logic [CW-1:0] n_q, k_q, i_q;
	logic [CW-1:0] n_eff;
	logic signed [31:0] qx_q, t0_q, t1_q, p_q, acc_q, res_q;
	logic sat_q, ph_q;
	logic [1:0] stat_q;
	logic dgo, ddone, dsat;
	logic signed [31:0] dq;
	logic signed [63:0] prod_s1;
	logic signed [31:0] mop_a, mop_b;
	logic [32:0] s_num, s_den, s_sub;

	assign cfg_ready = 1'b1;
	assign busy = (st_q != S_IDLE);

	always_comb begin
		if (pc_q == 5'd0) n_eff = CW'(1);
		else if (32'(pc_q) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
		else n_eff = CW'(pc_q);
	end

	ndd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .a(t0_q), .b(t1_q),
		.done(ddone), .q(dq), .sat(dsat)
	);

	// node memories
	always_ff @(posedge clk) begin
		if (start && !busy && in_item.action == ACT_LOAD &&
				32'(in_item.node_index) < MAX_POINTS) begin
			xmem[AW'(in_item.node_index)] <= in_item.node_x;
			ymem[AW'(in_item.node_index)] <= in_item.node_y;
		end
		xrd_q <= xmem[xra];
		yrd_q <= ymem[dra];
	end

	always_ff @(posedge clk) begin
		if (dwe) dmem[dwa] <= dwd;
		drd_q <= dmem[dra];
	end

	// multiply stage, registered; floor shift via arithmetic shift
	always_ff @(posedge clk) prod_s1 <= mop_a * mop_b;

	assign s_num = sat34(34'(drd_q) - 34'(t0_q));
	assign s_sub = sat34(34'(qx_q) - 34'(xrd_q));
	assign s_den = sat34(34'(xrd_q) - 34'(t1_q));

	logic signed [63:0] shp;
	logic [32:0] msat, asat;
	assign shp = prod_s1 >>> FRAC_BITS;
	always_comb begin
		if (shp > 64'sh7FFFFFFF) msat = {1'b1, 32'h7FFFFFFF};
		else if (shp < -64'sh80000000) msat = {1'b1, 32'h80000000};
		else msat = {1'b0, shp[31:0]};
	end
	assign asat = sat34(34'(acc_q) + 34'($signed(msat[31:0])));

	// combinational control
	always_comb begin
		st_d = st_q;
		xra = '0;
		dra = '0;
		dwe = 1'b0;
		dwa = AW'(i_q);
		dwd = yrd_q;
		dgo = 1'b0;
		mop_a = p_q;
		mop_b = t0_q;
		unique case (st_q)
			S_IDLE: if (start && in_item.action == ACT_EVAL) st_d = S_COPY;
			S_COPY: begin
				// i_q walks reads; write trails by one via ph_q
				dra = AW'(i_q);
				dwe = ph_q;
				dwa = AW'(i_q - 1'b1);
				if (i_q == n_q) st_d = (n_q == CW'(1)) ? S_DONE : S_RD;
			end
			S_RD: begin
				// read d[i], x[i] first
				dra = AW'(i_q);
				xra = AW'(i_q);
				st_d = S_RD2;
			end
			S_RD2: begin
				dra = AW'(i_q + 1'b1);
				xra = AW'(i_q + k_q);
				st_d = S_SUB;
			end
			S_SUB: st_d = (s_den[31:0] == 32'd0) ? S_DONE : S_DIV;
			S_DIV: begin
				dgo = !ph_q;
				if (ddone) st_d = S_DWR;
			end
			S_DWR: begin
				dwe = 1'b1;
				dwa = AW'(i_q);
				dwd = dq;
				xra = AW'(k_q - 1'b1);
				dra = '0;
				if (i_q + k_q + 1'b1 >= n_q) st_d = S_PMUL;
				else st_d = S_RD;
			end
			S_PMUL: begin
				xra = AW'(k_q - 1'b1);
				mop_a = p_q;
				mop_b = $signed(s_sub[31:0]);
				st_d = ph_q ? S_AMUL : S_PMUL;
			end
			S_AMUL: begin
				// p_q already holds the new running product
				dra = '0;
				mop_a = p_q;
				mop_b = drd_q;
				st_d = ph_q ? S_ACC : S_AMUL;
			end
			S_ACC: st_d = (k_q + 1'b1 >= n_q) ? S_DONE : S_RD;
			S_DONE: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pc_q <= POINT_COUNT_RST;
			done <= 1'b0;
			ph_q <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= (st_q == S_DONE);
			if (cfg_valid) pc_q <= cfg_data;
			if (st_q == S_PMUL || st_q == S_AMUL) ph_q <= !ph_q;
			else if (st_q == S_COPY) ph_q <= 1'b1;
			else ph_q <= (st_d == st_q);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				n_q <= n_eff;
				qx_q <= in_item.query_x;
				i_q <= '0;
				k_q <= CW'(1);
				sat_q <= 1'b0;
				p_q <= 32'sd1 <<< FRAC_BITS;
				stat_q <= ST_OK;
			end
			S_COPY: begin
				if (i_q == n_q) begin
					i_q <= '0;
					if (n_q == CW'(1)) acc_q <= yrd_q;
				end else begin
					i_q <= i_q + 1'b1;
					if (i_q == CW'(1)) acc_q <= yrd_q;
				end
			end
			S_RD2: begin
				t0_q <= drd_q;
				t1_q <= xrd_q;
			end
			S_SUB: begin
				t0_q <= $signed(s_num[31:0]);
				t1_q <= $signed(s_den[31:0]);
				sat_q <= sat_q | s_num[32] | s_den[32];
				if (s_den[31:0] == 32'd0) stat_q <= ST_ZDIV;
			end
			S_DIV: if (ddone) sat_q <= sat_q | dsat;
			S_DWR: i_q <= i_q + 1'b1;
			S_PMUL: if (!ph_q) sat_q <= sat_q | s_sub[32];
			else begin
				p_q <= $signed(msat[31:0]);
				sat_q <= sat_q | msat[32];
			end
			S_AMUL: ;
			S_ACC: begin
				acc_q <= $signed(asat[31:0]);
				sat_q <= sat_q | msat[32] | asat[32];
				k_q <= k_q + 1'b1;
				i_q <= '0;
			end
			S_DONE: begin
				if (stat_q == ST_ZDIV) res_q <= '0;
				else res_q <= acc_q;
				if (stat_q != ST_ZDIV) stat_q <= sat_q ? ST_SAT : ST_OK;
			end
			default: ;
		endcase
	end

	assign out_item.interp_value = res_q;
	assign out_item.status = stat_q;
endmodule
`default_nettype wire

// ===== rtl/core/ndd_checker.sv =====
// Port-level checker for the interpolator, bound to the top level.
// Uses ndd_pkg.
`default_nettype none
module ndd_checker import ndd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire in_item_t in_item,
	input wire logic done,
	input wire out_item_t out_item
);
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_item.action == ACT_EVAL |=> busy)
		else $error("evaluate not taken");
	a_zdiv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_item.status == ST_ZDIV |-> out_item.interp_value == 0)
		else $error("zero divisor result not zero");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_item.status != 2'd3) else $error("bad status");
endmodule
bind newton_divided_difference_interp ndd_checker u_chk (.*);
`default_nettype wire

// ===== sim/newton_divided_difference_interp_tb.sv =====
// Testbench for newton_divided_difference_interp: directed table, then random load/evaluate phases.
// Checks results against a built-in fixed-point predictor or fixed rows. Uses ndd_pkg and RTL top.
`default_nettype none
module newton_divided_difference_interp_tb import ndd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 16;
	localparam longint Q_HI = 64'sd2147483647;
	localparam longint Q_LO = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 8000000;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t in_item;
	logic done;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [4:0] cfg_data;

	newton_divided_difference_interp dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.done(done),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// predictor state: node stores and the point count register
	longint node_xs[NODES];
	longint node_ys[NODES];
	int unsigned count_reg;

	out_item_t expected_results[$];
	int errors;
	int cycles;

	typedef struct {
		in_item_t it;
		bit fixed;      // expected result typed in below
		out_item_t ex;
	} row_t;
	row_t directed[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run-length watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint clamp32(input longint v, inout bit hit);
		if (v > Q_HI) begin
			hit = 1'b1;
			return Q_HI;
		end
		if (v < Q_LO) begin
			hit = 1'b1;
			return Q_LO;
		end
		return v;
	endfunction

	// product in Q16.16: exact 64-bit, floor shift, saturate
	function automatic longint fx_mul(input longint a, input longint b, inout bit hit);
		longint p;
		p = a * b;
		return clamp32(p >>> FRAC_BITS_DEF, hit);
	endfunction

	// quotient in Q16.16: truncate toward zero, saturate
	function automatic longint fx_div(input longint a, input longint b, inout bit hit);
		longint n;
		n = a * (64'sd1 <<< FRAC_BITS_DEF);
		return clamp32(n / b, hit);
	endfunction

	// Applies one item to the predictor; returns 1 when it makes a result.
	function automatic bit interp_predict(input in_item_t it, output out_item_t r);
		longint dd[NODES];
		longint n, p, acc, num, den, xq;
		bit hit;
		r = '0;
		hit = 1'b0;
		if (it.action == ACT_LOAD) begin
			node_xs[it.node_index] = longint'($signed(it.node_x));
			node_ys[it.node_index] = longint'($signed(it.node_y));
			return 1'b0;
		end
		n = count_reg;
		if (n < 1) n = 1;
		if (n > NODES) n = NODES;
		for (int i = 0; i < n; i++) dd[i] = node_ys[i];
		xq = longint'($signed(it.query_x));
		p = 64'sd1 <<< FRAC_BITS_DEF;
		acc = dd[0];
		for (int k = 1; k < n; k++) begin
			for (int i = 0; i < n - k; i++) begin
				num = clamp32(dd[i + 1] - dd[i], hit);
				den = clamp32(node_xs[i + k] - node_xs[i], hit);
				if (den == 0) begin
					r.interp_value = '0;
					r.status = ST_ZDIV;
					return 1'b1;
				end
				dd[i] = fx_div(num, den, hit);
			end
			p = fx_mul(p, clamp32(xq - node_xs[k - 1], hit), hit);
			acc = clamp32(acc + fx_mul(p, dd[0], hit), hit);
		end
		r.interp_value = acc[31:0];
		r.status = hit ? ST_SAT : ST_OK;
		return 1'b1;
	endfunction

	// result checker: results cannot be stalled, take each one as it comes
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: got value %h status %0d", $realtime,
					out_item.interp_value, out_item.status);
				errors++;
			end else begin
				if (out_item.interp_value !== expected_results[0].interp_value) begin
					$display("%0t interp_value mismatch: expected %h actual %h", $realtime,
						expected_results[0].interp_value, out_item.interp_value);
					errors++;
				end
				if (out_item.status !== expected_results[0].status) begin
					$display("%0t status mismatch: expected %0d actual %0d", $realtime,
						expected_results[0].status, out_item.status);
					errors++;
				end
				void'(expected_results.pop_front());
			end
		end
	end

	// mostly short gaps, a few long ones; zero when idling is off
	function automatic int pick_gap(input bit no_idle);
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// One start/busy transfer. start stays high across back-to-back items.
	task automatic send_item(input in_item_t it, input int gap, input bit fixed,
			input out_item_t fixed_res);
		out_item_t r;
		bit has_res;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		in_item <= it;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		has_res = interp_predict(it, r);
		if (has_res) expected_results.push_back(fixed ? fixed_res : r);
	endtask

	// Register write while idle: drain results, let a pending load finish.
	task automatic write_count(input logic [4:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		count_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_x(input int unsigned idx);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return (idx << 16) + $urandom_range(0, 32767) - 16384;
		if (r < 85) return $urandom;
		return node_xs[$urandom_range(0, NODES - 1)][31:0];   // repeated abscissa
	endfunction

	function automatic logic [31:0] rand_val();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
	endfunction

	function automatic row_t mk_row(input logic act, input logic [3:0] idx,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] q,
			input bit fixed, input logic [31:0] ev, input logic [1:0] es);
		row_t row;
		row.it.action = act;
		row.it.node_index = idx;
		row.it.node_x = x;
		row.it.node_y = y;
		row.it.query_x = q;
		row.fixed = fixed;
		row.ex.interp_value = ev;
		row.ex.status = es;
		return row;
	endfunction

	initial begin
		logic [4:0] counts[] = '{5'd1, 5'd0, 5'd2, 5'd3, 5'd31, 5'd4, 5'd5, 5'd16,
			5'd6, 5'd8, 5'd2, 5'd7, 5'd3, 5'd5};
		in_item_t it;
		out_item_t none;
		int eff, n_items, eval_pct;
		bit no_idle;

		errors = 0;
		cycles = 0;
		start = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		none = '0;
		count_reg = POINT_COUNT_RST;
		for (int i = 0; i < NODES; i++) begin
			node_xs[i] = 0;
			node_ys[i] = 0;
		end

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill every node first so no evaluation reads an unwritten one
		for (int i = 0; i < NODES; i++)
			directed.push_back(mk_row(ACT_LOAD, 4'(i), i << 16,
				(i == 0) ? 32'h7FFFFFFF : (i == 1) ? 32'h80000000 : (i * 3) << 16,
				32'hFFFFFFFF, 1'b0, '0, ST_OK));
		directed.push_back(mk_row(ACT_EVAL, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,
			1'b0, '0, ST_OK));
		directed.push_back(mk_row(ACT_EVAL, 4'h0, 0, 0, 32'h7FFFFFFF, 1'b0, '0, ST_OK));
		directed.push_back(mk_row(ACT_EVAL, 4'h0, 0, 0, 32'h80000000, 1'b0, '0, ST_OK));
		// node 1 on top of node 0: zero divisor
		directed.push_back(mk_row(ACT_LOAD, 4'd1, 32'h0, 32'h0, 0, 1'b0, '0, ST_OK));
		directed.push_back(mk_row(ACT_EVAL, 4'd0, 0, 0, 32'h00010000, 1'b1, 32'h0, ST_ZDIV));
		directed.push_back(mk_row(ACT_LOAD, 4'd1, 32'h00010000, 32'h00050000, 0,
			1'b0, '0, ST_OK));
		directed.push_back(mk_row(ACT_EVAL, 4'd0, 0, 0, 32'h00028000, 1'b0, '0, ST_OK));
		directed.push_back(mk_row(ACT_LOAD, 4'd0, 32'h0, 32'h00020000, 0, 1'b0, '0, ST_OK));
		directed.push_back(mk_row(ACT_EVAL, 4'd0, 0, 0, 32'hFFFF8000, 1'b0, '0, ST_OK));

		foreach (directed[i])
			send_item(directed[i].it, pick_gap(1'b0), directed[i].fixed, directed[i].ex);

		// random phases, one point count each; extremes 0, 1, 16 and 31 included
		foreach (counts[ph]) begin
			write_count(counts[ph]);
			eff = (counts[ph] < 1) ? 1 : (counts[ph] > NODES) ? NODES : counts[ph];
			n_items = (eff > 8) ? 40 : 125;
			eval_pct = (eff > 8) ? 15 : 35;
			no_idle = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < n_items; j++) begin
				it.node_index = 4'($urandom_range(0, NODES - 1));
				it.node_x = rand_x(it.node_index);
				it.node_y = rand_val();
				it.query_x = rand_val();
				it.action = ($urandom_range(0, 99) < eval_pct) ? ACT_EVAL : ACT_LOAD;
				send_item(it, pick_gap(no_idle), 1'b0, none);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0 || busy) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
